@@ rtl/ptte_pkg.sv @@
// Package for the pointer to touch event translator: codes, widths and types.
package ptte_pkg;

   localparam int BUTTON_COUNT_DEF = 30;
   localparam int RANGE_W = 16;
   localparam int COORD_W = 16;
   localparam int REG_W = 14;
   localparam int POS_W = 23;
   localparam int PIX_W = 15;
   localparam int SUM_W = 16;
   localparam int PROD_W = SUM_W + RANGE_W;
   localparam int VALUE_W = 17;
   localparam int CODE_W = 10;

   localparam logic [RANGE_W-1:0] TOUCH_RANGE_X = 16'd32767;
   localparam logic [RANGE_W-1:0] TOUCH_RANGE_Y = 16'd32767;
   localparam logic [VALUE_W-1:0] CONTACT_ID = 17'd3;
   localparam logic [VALUE_W-1:0] TRACK_RELEASE = 17'h1FFFF;
   localparam logic [CODE_W-1:0] MOUSE_BASE = 10'h110;

   localparam logic [1:0] MODE_MOTION = 2'd0;
   localparam logic [1:0] MODE_BUTTON = 2'd1;

   localparam logic [1:0] EVT_SYNC = 2'd0;
   localparam logic [1:0] EVT_ABS = 2'd3;
   localparam logic [5:0] CODE_SYNC = 6'h00;
   localparam logic [5:0] CODE_SLOT = 6'h2f;
   localparam logic [5:0] CODE_X = 6'h35;
   localparam logic [5:0] CODE_Y = 6'h36;
   localparam logic [5:0] CODE_TRACK = 6'h39;

   localparam logic [1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_WIDTH = 2'd2;
   localparam logic [1:0] CSR_OUTPUT_HEIGHT = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SETUP,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RUN_DOWN,
      RUN_UP,
      RUN_MOTION
   } run_type;

   typedef enum logic [2:0] {
      EV_SLOT,
      EV_TRACK,
      EV_X,
      EV_Y,
      EV_SYNC
   } sel_type;

endpackage

@@ rtl/pointer_to_touch_event_translator.sv @@
// Top level of the pointer to touch event translator, emulating one touch contact.
// Button items, ignored items and motion items with nothing to send are taken in the idle state.
// Touch down or motion: x then y on one shared multiplier and bit-serial divider, the divide
// skipped for an axis that saturates, then the events of the run are sent in order.
// A touch up skips the arithmetic and goes straight to its events; rsp_ready low stalls them.
// Synchronous active-high reset clears the button mask, the touch and pending flags.
module pointer_to_touch_event_translator #(
   parameter int BUTTON_COUNT = ptte_pkg::BUTTON_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [ptte_pkg::REG_W-1:0]        csr_wdata,
   // Pointer item channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [ptte_pkg::POS_W-1:0]        req_pos_x_fixed,
   input  logic [ptte_pkg::POS_W-1:0]        req_pos_y_fixed,
   input  logic [ptte_pkg::CODE_W-1:0]       req_button_code,
   input  logic                              req_pressed,
   // Touch event channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_event_type,
   output logic [5:0]                        rsp_event_code,
   output logic signed [ptte_pkg::VALUE_W-1:0] rsp_event_value,
   output logic                              rsp_last_event
);

   // Configuration registers.
   logic [ptte_pkg::REG_W-1:0] origin_x_ff, origin_y_ff, width_ff, height_ff;

   // Tracking state.
   logic [BUTTON_COUNT-1:0] held_ff, held_in;
   logic touch_ff, touch_in;
   logic pending_ff, pending_in;

   // Sequencer.
   ptte_pkg::state_type state_ff, state_in;
   ptte_pkg::run_type run_ff, run_in;
   logic [2:0] event_ff, event_in;

   // Shared arithmetic datapath.
   logic axis_ff, axis_in;
   logic [ptte_pkg::PIX_W-1:0] pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic [ptte_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [ptte_pkg::REG_W-1:0] rem_ff, rem_in;
   logic [ptte_pkg::COORD_W-1:0] low_ff, low_in, quot_ff, quot_in;
   logic [3:0] step_ff, step_in;
   logic [ptte_pkg::COORD_W-1:0] coord_x_ff, coord_x_in, coord_y_ff, coord_y_in;

   // Item decode.
   logic req_fire, rsp_fire;
   logic [ptte_pkg::CODE_W-1:0] btn_idx;
   logic btn_ok;
   logic [BUTTON_COUNT-1:0] btn_bit, held_set, held_clr;
   logic motion_emits;
   ptte_pkg::run_type motion_run;

   // Axis operands and the divider step.
   logic [ptte_pkg::REG_W-1:0] size_sel, origin_sel;
   logic [ptte_pkg::PIX_W-1:0] pix_sel;
   logic [ptte_pkg::RANGE_W-1:0] range_sel;
   logic [ptte_pkg::SUM_W-1:0] sum_sel;
   logic [ptte_pkg::PROD_W-1:0] prod_calc;
   logic saturate;
   logic [ptte_pkg::REG_W:0] trial;
   logic trial_ge;
   logic [ptte_pkg::COORD_W-1:0] quot_next;
   logic coord_done;

   // Output selection.
   ptte_pkg::sel_type ev_sel;
   logic ev_last;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign csr_ready = 1'b1;

   // Configuration is written whenever offered; the user writes only while idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff <= 14'd1920;
         height_ff <= 14'd1080;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ptte_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            ptte_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            ptte_pkg::CSR_OUTPUT_WIDTH: width_ff <= csr_wdata;
            ptte_pkg::CSR_OUTPUT_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Button decode: the index is the code less the mouse base, and codes outside
   // the tracked buttons are dropped.
   assign btn_idx = req_button_code - ptte_pkg::MOUSE_BASE;
   assign btn_ok = (req_button_code >= ptte_pkg::MOUSE_BASE) &&
                   (btn_idx < ptte_pkg::CODE_W'(BUTTON_COUNT));

   always_comb begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         btn_bit[i] = (btn_idx == ptte_pkg::CODE_W'(i));
      end
   end

   assign held_set = held_ff | btn_bit;
   assign held_clr = held_ff & ~btn_bit;

   // A motion item turns a pending change into a touch down or up when the mask
   // disagrees with the touch flag; with no change pending, held buttons move it.
   always_comb begin
      motion_emits = 1'b0;
      motion_run = ptte_pkg::RUN_MOTION;
      if (pending_ff) begin
         if (touch_ff && (held_ff == '0)) begin
            motion_emits = 1'b1;
            motion_run = ptte_pkg::RUN_UP;
         end else if (!touch_ff && (held_ff != '0)) begin
            motion_emits = 1'b1;
            motion_run = ptte_pkg::RUN_DOWN;
         end
      end else if (held_ff != '0) begin
         motion_emits = 1'b1;
      end
   end

   // Operands of the axis now in the shared unit.
   assign size_sel = axis_ff ? height_ff : width_ff;
   assign origin_sel = axis_ff ? origin_y_ff : origin_x_ff;
   assign pix_sel = axis_ff ? pix_y_ff : pix_x_ff;
   assign range_sel = axis_ff ? ptte_pkg::TOUCH_RANGE_Y : ptte_pkg::TOUCH_RANGE_X;
   assign sum_sel = ptte_pkg::SUM_W'(pix_sel) + ptte_pkg::SUM_W'(origin_sel);
   assign prod_calc = sum_sel * range_sel;

   // The quotient exceeds the coordinate range exactly when the upper half of
   // the product reaches the divisor; a zero divisor saturates the same way.
   assign saturate = prod_ff[ptte_pkg::PROD_W-1:ptte_pkg::COORD_W] >=
                     ptte_pkg::COORD_W'(size_sel);

   // One restoring division step; the remainder always stays below the divisor.
   assign trial = {rem_ff, low_ff[ptte_pkg::COORD_W-1]};
   assign trial_ge = trial >= {1'b0, size_sel};
   assign quot_next = {quot_ff[ptte_pkg::COORD_W-2:0], trial_ge};
   assign coord_done = (step_ff == 4'd0);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptte_pkg::ST_IDLE: begin
            if (req_fire && (req_mode == ptte_pkg::MODE_MOTION) && motion_emits) begin
               state_in = (motion_run == ptte_pkg::RUN_UP) ? ptte_pkg::ST_EMIT
                                                            : ptte_pkg::ST_MUL;
            end
         end
         ptte_pkg::ST_MUL: state_in = ptte_pkg::ST_SETUP;
         ptte_pkg::ST_SETUP: begin
            if (saturate) begin
               state_in = axis_ff ? ptte_pkg::ST_EMIT : ptte_pkg::ST_MUL;
            end else begin
               state_in = ptte_pkg::ST_DIV;
            end
         end
         ptte_pkg::ST_DIV: begin
            if (coord_done) begin
               state_in = axis_ff ? ptte_pkg::ST_EMIT : ptte_pkg::ST_MUL;
            end
         end
         ptte_pkg::ST_EMIT: begin
            if (rsp_fire && ev_last) begin
               state_in = ptte_pkg::ST_IDLE;
            end
         end
         default: state_in = ptte_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs of the sequencer.
   always_comb begin
      req_ready = (state_ff == ptte_pkg::ST_IDLE);
      rsp_valid = (state_ff == ptte_pkg::ST_EMIT);
   end

   // Tracking state and datapath updates.
   always_comb begin
      held_in = held_ff;
      touch_in = touch_ff;
      pending_in = pending_ff;
      run_in = run_ff;
      event_in = event_ff;
      axis_in = axis_ff;
      pix_x_in = pix_x_ff;
      pix_y_in = pix_y_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      coord_x_in = coord_x_ff;
      coord_y_in = coord_y_ff;
      case (state_ff)
         ptte_pkg::ST_IDLE: begin
            pix_x_in = req_pos_x_fixed[ptte_pkg::POS_W-1:8];
            pix_y_in = req_pos_y_fixed[ptte_pkg::POS_W-1:8];
            axis_in = 1'b0;
            event_in = '0;
            if (req_fire && (req_mode == ptte_pkg::MODE_BUTTON) && btn_ok) begin
               if (req_pressed) begin
                  held_in = held_set;
                  if (held_ff == '0) begin
                     pending_in = 1'b1;
                  end
               end else begin
                  held_in = held_clr;
                  if (held_clr == '0) begin
                     pending_in = 1'b1;
                  end
               end
            end else if (req_fire && (req_mode == ptte_pkg::MODE_MOTION)) begin
               pending_in = 1'b0;
               run_in = motion_run;
               if (pending_ff && motion_emits) begin
                  touch_in = (motion_run == ptte_pkg::RUN_DOWN);
               end
            end
         end
         ptte_pkg::ST_MUL: prod_in = prod_calc;
         ptte_pkg::ST_SETUP: begin
            rem_in = prod_ff[ptte_pkg::COORD_W +: ptte_pkg::REG_W];
            low_in = prod_ff[ptte_pkg::COORD_W-1:0];
            quot_in = '0;
            step_in = 4'd15;
            if (saturate) begin
               if (axis_ff) begin
                  coord_y_in = '1;
               end else begin
                  coord_x_in = '1;
               end
               axis_in = 1'b1;
            end
         end
         ptte_pkg::ST_DIV: begin
            rem_in = trial_ge ? ptte_pkg::REG_W'(trial - {1'b0, size_sel})
                              : trial[ptte_pkg::REG_W-1:0];
            low_in = {low_ff[ptte_pkg::COORD_W-2:0], 1'b0};
            quot_in = quot_next;
            step_in = step_ff - 4'd1;
            if (coord_done) begin
               if (axis_ff) begin
                  coord_y_in = quot_next;
               end else begin
                  coord_x_in = quot_next;
               end
               axis_in = 1'b1;
            end
         end
         ptte_pkg::ST_EMIT: begin
            if (rsp_fire) begin
               event_in = event_ff + 3'd1;
            end
         end
         default: ;
      endcase
   end

   // Which event of the run is presented now.
   always_comb begin
      ev_sel = ptte_pkg::EV_SYNC;
      case (run_ff)
         ptte_pkg::RUN_DOWN: begin
            case (event_ff)
               3'd0: ev_sel = ptte_pkg::EV_SLOT;
               3'd1: ev_sel = ptte_pkg::EV_TRACK;
               3'd2: ev_sel = ptte_pkg::EV_X;
               3'd3: ev_sel = ptte_pkg::EV_Y;
               default: ev_sel = ptte_pkg::EV_SYNC;
            endcase
         end
         ptte_pkg::RUN_UP: begin
            case (event_ff)
               3'd0: ev_sel = ptte_pkg::EV_SLOT;
               3'd1: ev_sel = ptte_pkg::EV_TRACK;
               default: ev_sel = ptte_pkg::EV_SYNC;
            endcase
         end
         default: begin
            case (event_ff)
               3'd0: ev_sel = ptte_pkg::EV_SLOT;
               3'd1: ev_sel = ptte_pkg::EV_X;
               3'd2: ev_sel = ptte_pkg::EV_Y;
               default: ev_sel = ptte_pkg::EV_SYNC;
            endcase
         end
      endcase
   end

   assign ev_last = (ev_sel == ptte_pkg::EV_SYNC);

   // Event payload; a touch up carries the release tracking id.
   always_comb begin
      rsp_event_type = ptte_pkg::EVT_ABS;
      rsp_last_event = ev_last;
      case (ev_sel)
         ptte_pkg::EV_SLOT: begin
            rsp_event_code = ptte_pkg::CODE_SLOT;
            rsp_event_value = ptte_pkg::CONTACT_ID;
         end
         ptte_pkg::EV_TRACK: begin
            rsp_event_code = ptte_pkg::CODE_TRACK;
            rsp_event_value = (run_ff == ptte_pkg::RUN_UP) ? ptte_pkg::TRACK_RELEASE
                                                           : ptte_pkg::CONTACT_ID;
         end
         ptte_pkg::EV_X: begin
            rsp_event_code = ptte_pkg::CODE_X;
            rsp_event_value = {1'b0, coord_x_ff};
         end
         ptte_pkg::EV_Y: begin
            rsp_event_code = ptte_pkg::CODE_Y;
            rsp_event_value = {1'b0, coord_y_ff};
         end
         default: begin
            rsp_event_type = ptte_pkg::EVT_SYNC;
            rsp_event_code = ptte_pkg::CODE_SYNC;
            rsp_event_value = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptte_pkg::ST_IDLE;
         held_ff <= '0;
         touch_ff <= 1'b0;
         pending_ff <= 1'b0;
         event_ff <= '0;
         axis_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         held_ff <= held_in;
         touch_ff <= touch_in;
         pending_ff <= pending_in;
         event_ff <= event_in;
         axis_ff <= axis_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      pix_x_ff <= pix_x_in;
      pix_y_ff <= pix_y_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quot_ff <= quot_in;
      coord_x_ff <= coord_x_in;
      coord_y_ff <= coord_y_in;
   end

   // The touch flag moves only on an accepted motion item.
   a_touch_on_motion: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(touch_ff)) |->
         $past(req_valid && req_ready && (req_mode == ptte_pkg::MODE_MOTION)))
      else $error("touch flag changed without a motion item");

   // A touch-up run never uses the arithmetic unit.
   a_up_no_math: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptte_pkg::ST_MUL) |-> (run_ff != ptte_pkg::RUN_UP))
      else $error("touch-up run entered the multiplier");

   // Taking the closing sync event frees the block for the next item.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_event) |=> req_ready)
      else $error("block not ready after the closing event");

   // The block never takes an item while a run is being delivered.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready while events are pending");

endmodule
